// ----- rtl/core/mfd_pkg.sv -----
package mfd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOR_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_EN   = 3'd5;

    localparam int CFG_DATA_W = 32;
    localparam int ID_W       = 11;
    localparam int PAYLOAD_W  = 64;
    localparam int POS_W      = 16;
    localparam int RAW12_W    = 12;
    localparam int OFS_W      = 17;
    localparam int CNT_W      = 13;
    localparam int TURN_EXT_W = 32;
    localparam int TURNS_W    = 24;
    localparam int ANGLE_W    = 48;
    localparam int SCALED_W   = 32;
    localparam int GAIN_W     = 32;
    localparam int DIFF_W     = 50;
    localparam int ANG_PROD_W = DIFF_W + GAIN_W;
    localparam int SMALL_PROD_W = CNT_W + GAIN_W;
    localparam int FRAC_DROP  = 8;

    localparam int FRAMES_W = 6;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 6'd63;
    localparam logic [FRAMES_W-1:0] ZERO_FRAME = 6'd50;

    localparam logic [POS_W-1:0] POS_RESET    = 16'd32768;
    localparam logic [POS_W-1:0] POS_LOW_MAX  = 16'd16383;
    localparam logic [POS_W-1:0] POS_HIGH_MIN = 16'd49152;

    typedef struct packed {
        logic [ID_W-1:0]         host_id;
        logic [3:0]              motor_id;
        logic signed [GAIN_W-1:0] pos_gain;
        logic signed [GAIN_W-1:0] vel_gain;
        logic signed [GAIN_W-1:0] tor_gain;
        logic                    zero_en;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] drv_temp;
        logic signed [7:0] rot_temp;
        logic [3:0]        fault_state;
    } t_side;

    typedef struct packed {
        logic signed [TURN_EXT_W-1:0] turn;
        logic signed [OFS_W-1:0]      zoff;
        logic [POS_W-1:0]             pos;
        logic [RAW12_W-1:0]           vel;
        logic [RAW12_W-1:0]           tor;
        t_side                        side;
    } t_trk;

endpackage

// ----- rtl/core/motor_feedback_frame_decoder.sv -----
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_stall    | i_cmd, i_std_frame, i_frame_id, i_payload
// out      | output    | o_out_valid / i_out_stall  | o_abs_angle .. o_turns
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained unless the output stalls; a kept frame passes the
// input register, tracking, difference and product stages before the output register
// turn and zero-offset state update as a kept frame or reset command leaves input register
// reset is synchronous and active low; it clears valids, state and config, no clearing pass
// an output stall backs up the pipeline stage by stage; bubbles are squeezed out
module motor_feedback_frame_decoder
    import mfd_pkg::*;
#(
    parameter int TURN_WIDTH = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic                       i_std_frame,
    input  logic [ID_W-1:0]            i_frame_id,
    input  logic [PAYLOAD_W-1:0]       i_payload,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [ANGLE_W-1:0]  o_abs_angle,
    output logic signed [SCALED_W-1:0] o_velocity,
    output logic signed [SCALED_W-1:0] o_torque,
    output logic signed [7:0]          o_drv_temp,
    output logic signed [7:0]          o_rot_temp,
    output logic [3:0]                 o_fault_state,
    output logic signed [TURNS_W-1:0]  o_turns
);

    t_cfg r_cfg;
    logic trk_valid;
    logic trk_ready;
    t_trk trk;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOST_ID:  r_cfg.host_id  <= i_cfg_data[ID_W-1:0];
                CFG_MOTOR_ID: r_cfg.motor_id <= i_cfg_data[3:0];
                CFG_POS_GAIN: r_cfg.pos_gain <= i_cfg_data;
                CFG_VEL_GAIN: r_cfg.vel_gain <= i_cfg_data;
                CFG_TOR_GAIN: r_cfg.tor_gain <= i_cfg_data;
                CFG_ZERO_EN:  r_cfg.zero_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mfd_track #(
        .TURN_WIDTH(TURN_WIDTH)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_std_frame(i_std_frame),
        .i_frame_id (i_frame_id),
        .i_payload  (i_payload),
        .o_valid    (trk_valid),
        .i_ready    (trk_ready),
        .o_trk      (trk)
    );

    mfd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (trk_valid),
        .o_ready      (trk_ready),
        .i_trk        (trk),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_abs_angle  (o_abs_angle),
        .o_velocity   (o_velocity),
        .o_torque     (o_torque),
        .o_drv_temp   (o_drv_temp),
        .o_rot_temp   (o_rot_temp),
        .o_fault_state(o_fault_state),
        .o_turns      (o_turns)
    );

endmodule

// ----- rtl/core/mfd_track.sv -----
module mfd_track
    import mfd_pkg::*;
#(
    parameter int TURN_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic                 i_std_frame,
    input  logic [ID_W-1:0]      i_frame_id,
    input  logic [PAYLOAD_W-1:0] i_payload,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_trk                 o_trk
);

    localparam logic signed [TURN_WIDTH-1:0] TURN_MAX = {1'b0, {(TURN_WIDTH-1){1'b1}}};
    localparam logic signed [TURN_WIDTH-1:0] TURN_MIN = {1'b1, {(TURN_WIDTH-1){1'b0}}};

    logic                 r_s0_valid;
    logic                 r_cmd;
    logic                 r_std;
    logic [ID_W-1:0]      r_id;
    logic [PAYLOAD_W-1:0] r_payload;

    logic signed [TURN_WIDTH-1:0] r_turn, n_turn;
    logic signed [OFS_W-1:0]      r_zoff, n_zoff;
    logic [POS_W-1:0]             r_last, n_last;
    logic [FRAMES_W-1:0]          r_frames, n_frames;

    logic r_s1_valid;
    t_trk r_s1;

    logic                    keep;
    logic                    s0_adv;
    logic                    s0_ready;
    logic                    s1_ready;
    logic [POS_W-1:0]        raw_pos;
    logic signed [OFS_W-1:0] pos_c;
    logic signed [OFS_W-1:0] last_c;
    logic [FRAMES_W-1:0]     frames_inc;
    t_trk                    s1_next;

    assign raw_pos = r_payload[55:40];
    assign pos_c   = {~raw_pos[POS_W-1], raw_pos[POS_W-2:0], 1'b1};
    assign last_c  = {~r_last[POS_W-1], r_last[POS_W-2:0], 1'b1};

    assign keep = !r_cmd && r_std && (r_id == i_cfg.host_id)
                  && (r_payload[59:56] == i_cfg.motor_id);

    assign s1_ready   = !r_s1_valid || i_ready;
    assign s0_adv     = r_s0_valid && (s1_ready || !keep);
    assign s0_ready   = !r_s0_valid || s0_adv;
    assign o_in_stall = !s0_ready;

    assign frames_inc = (r_frames != FRAMES_MAX) ? r_frames + FRAMES_W'(1) : r_frames;

    always_comb begin
        n_turn   = r_turn;
        n_zoff   = r_zoff;
        n_last   = r_last;
        n_frames = r_frames;
        if (s0_adv) begin
            if (r_cmd) begin
                n_turn = '0;
                n_zoff = last_c;
            end else if (keep) begin
                if (raw_pos <= POS_LOW_MAX && r_last >= POS_HIGH_MIN) begin
                    if (r_turn != TURN_MAX) begin
                        n_turn = r_turn + TURN_WIDTH'(1);
                    end
                end else if (raw_pos >= POS_HIGH_MIN && r_last <= POS_LOW_MAX) begin
                    if (r_turn != TURN_MIN) begin
                        n_turn = r_turn - TURN_WIDTH'(1);
                    end
                end
                n_last   = raw_pos;
                n_frames = frames_inc;
                if (frames_inc == ZERO_FRAME && i_cfg.zero_en) begin
                    n_turn = '0;
                    n_zoff = pos_c;
                end
            end
        end
    end

    always_comb begin
        s1_next.turn             = TURN_EXT_W'(n_turn);
        s1_next.zoff             = n_zoff;
        s1_next.pos              = raw_pos;
        s1_next.vel              = r_payload[39:28];
        s1_next.tor              = r_payload[27:16];
        s1_next.side.drv_temp    = r_payload[15:8];
        s1_next.side.rot_temp    = r_payload[7:0];
        s1_next.side.fault_state = r_payload[63:60];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_turn     <= '0;
            r_zoff     <= '0;
            r_last     <= POS_RESET;
            r_frames   <= '0;
        end else begin
            if (s0_ready) begin
                r_s0_valid <= i_in_valid;
            end
            if (s0_adv && keep) begin
                r_s1_valid <= 1'b1;
            end else if (i_ready) begin
                r_s1_valid <= 1'b0;
            end
            r_turn   <= n_turn;
            r_zoff   <= n_zoff;
            r_last   <= n_last;
            r_frames <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_in_valid) begin
            r_cmd     <= i_cmd;
            r_std     <= i_std_frame;
            r_id      <= i_frame_id;
            r_payload <= i_payload;
        end
        if (s0_adv && keep) begin
            r_s1 <= s1_next;
        end
    end

    assign o_valid = r_s1_valid;
    assign o_trk   = r_s1;

    a_cmd_clears_turns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_adv && r_cmd) |=> (r_turn == '0))
        else $error("turn counter not cleared by reset command");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("tracked frame lost while downstream busy");

    a_frames_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_frames >= $past(r_frames)))
        else $error("frame count went backward");

endmodule

// ----- rtl/core/mfd_scale.sv -----
module mfd_scale
    import mfd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_trk                       i_trk,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [ANGLE_W-1:0]  o_abs_angle,
    output logic signed [SCALED_W-1:0] o_velocity,
    output logic signed [SCALED_W-1:0] o_torque,
    output logic signed [7:0]          o_drv_temp,
    output logic signed [7:0]          o_rot_temp,
    output logic [3:0]                 o_fault_state,
    output logic signed [TURNS_W-1:0]  o_turns
);

    localparam int LO_W  = 32;
    localparam int HI_W  = DIFF_W - LO_W;
    localparam int PL_W  = LO_W + 1 + GAIN_W;
    localparam int PH_W  = HI_W + GAIN_W;
    localparam logic signed [ANG_PROD_W-1:0]   ANG_HALF   = ANG_PROD_W'(128);
    localparam logic signed [SMALL_PROD_W-1:0] SMALL_HALF = SMALL_PROD_W'(128);

    // stage 2: angle difference and centered counts
    logic                       r_s2_valid;
    logic signed [DIFF_W-1:0]   r_s2_d;
    logic signed [CNT_W-1:0]    r_s2_vc;
    logic signed [CNT_W-1:0]    r_s2_tc;
    t_side                      r_s2_side;
    logic [TURNS_W-1:0]         r_s2_turns;

    // stage 3: products
    logic                           r_s3_valid;
    logic signed [PL_W-1:0]         r_s3_pl;
    logic signed [PH_W-1:0]         r_s3_ph;
    logic signed [SMALL_PROD_W-1:0] r_s3_pv;
    logic signed [SMALL_PROD_W-1:0] r_s3_pt;
    t_side                          r_s3_side;
    logic [TURNS_W-1:0]             r_s3_turns;

    logic                       r_o_valid;
    logic signed [ANGLE_W-1:0]  r_o_angle;
    logic signed [SCALED_W-1:0] r_o_vel;
    logic signed [SCALED_W-1:0] r_o_tor;
    t_side                      r_o_side;
    logic [TURNS_W-1:0]         r_o_turns;

    logic out_ready, s3_ready, s2_ready;

    logic signed [DIFF_W-1:0] t_ext, c_ext, z_ext, d_next;
    logic signed [OFS_W-1:0]  pos_c;
    logic signed [CNT_W-1:0]  vc_next, tc_next;

    logic signed [LO_W:0]     d_lo;
    logic signed [HI_W-1:0]   d_hi;

    logic signed [ANG_PROD_W-1:0]   ang_sum;
    logic signed [SMALL_PROD_W-1:0] vel_sum, tor_sum;
    logic signed [ANGLE_W-1:0]      ang_q;
    logic signed [SCALED_W-1:0]     vel_q, tor_q;
    logic                           ang_fits, vel_fits, tor_fits;

    assign out_ready = !r_o_valid || !i_out_stall;
    assign s3_ready  = !r_s3_valid || out_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign o_ready   = s2_ready;

    // turns * 131070 + c - zero offset
    assign pos_c   = {~i_trk.pos[POS_W-1], i_trk.pos[POS_W-2:0], 1'b1};
    assign t_ext   = DIFF_W'(i_trk.turn);
    assign c_ext   = DIFF_W'(pos_c);
    assign z_ext   = DIFF_W'(i_trk.zoff);
    assign d_next  = (t_ext <<< 17) - (t_ext <<< 1) + c_ext - z_ext;
    assign vc_next = {~i_trk.vel[RAW12_W-1], i_trk.vel[RAW12_W-2:0], 1'b1};
    assign tc_next = {~i_trk.tor[RAW12_W-1], i_trk.tor[RAW12_W-2:0], 1'b1};

    assign d_lo = {1'b0, r_s2_d[LO_W-1:0]};
    assign d_hi = r_s2_d[DIFF_W-1:LO_W];

    // round half up into q.16, then saturate
    assign ang_sum  = (ANG_PROD_W'(r_s3_ph) <<< LO_W) + ANG_PROD_W'(r_s3_pl) + ANG_HALF;
    assign vel_sum  = r_s3_pv + SMALL_HALF;
    assign tor_sum  = r_s3_pt + SMALL_HALF;

    assign ang_fits = (&ang_sum[ANG_PROD_W-1:ANGLE_W+FRAC_DROP-1])
                      || !(|ang_sum[ANG_PROD_W-1:ANGLE_W+FRAC_DROP-1]);
    assign vel_fits = (&vel_sum[SMALL_PROD_W-1:SCALED_W+FRAC_DROP-1])
                      || !(|vel_sum[SMALL_PROD_W-1:SCALED_W+FRAC_DROP-1]);
    assign tor_fits = (&tor_sum[SMALL_PROD_W-1:SCALED_W+FRAC_DROP-1])
                      || !(|tor_sum[SMALL_PROD_W-1:SCALED_W+FRAC_DROP-1]);

    assign ang_q = ang_fits ? ang_sum[ANGLE_W+FRAC_DROP-1:FRAC_DROP]
                 : (ang_sum[ANG_PROD_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                          : {1'b0, {(ANGLE_W-1){1'b1}}});
    assign vel_q = vel_fits ? vel_sum[SCALED_W+FRAC_DROP-1:FRAC_DROP]
                 : (vel_sum[SMALL_PROD_W-1] ? {1'b1, {(SCALED_W-1){1'b0}}}
                                            : {1'b0, {(SCALED_W-1){1'b1}}});
    assign tor_q = tor_fits ? tor_sum[SCALED_W+FRAC_DROP-1:FRAC_DROP]
                 : (tor_sum[SMALL_PROD_W-1] ? {1'b1, {(SCALED_W-1){1'b0}}}
                                            : {1'b0, {(SCALED_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_s2_d     <= d_next;
            r_s2_vc    <= vc_next;
            r_s2_tc    <= tc_next;
            r_s2_side  <= i_trk.side;
            r_s2_turns <= i_trk.turn[TURNS_W-1:0];
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_pl    <= d_lo * i_cfg.pos_gain;
            r_s3_ph    <= d_hi * i_cfg.pos_gain;
            r_s3_pv    <= r_s2_vc * i_cfg.vel_gain;
            r_s3_pt    <= r_s2_tc * i_cfg.tor_gain;
            r_s3_side  <= r_s2_side;
            r_s3_turns <= r_s2_turns;
        end
        if (out_ready && r_s3_valid) begin
            r_o_angle <= ang_q;
            r_o_vel   <= vel_q;
            r_o_tor   <= tor_q;
            r_o_side  <= r_s3_side;
            r_o_turns <= r_s3_turns;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_abs_angle   = r_o_angle;
    assign o_velocity    = r_o_vel;
    assign o_torque      = r_o_tor;
    assign o_drv_temp    = r_o_side.drv_temp;
    assign o_rot_temp    = r_o_side.rot_temp;
    assign o_fault_state = r_o_side.fault_state;
    assign o_turns       = r_o_turns;

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_ready) |=> (r_s2_valid && $stable(r_s2_d)))
        else $error("angle difference dropped while pipeline stalled");

    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !out_ready) |=> (r_s3_valid && $stable(r_s3_pl)))
        else $error("products dropped while output stalled");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_out_stall) |=> (r_o_valid && $stable(r_o_angle)))
        else $error("output transaction changed while stalled");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import mfd_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 10;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     PRINT_CAP    = 100;
    localparam longint TURN_MAX     = (64'sd1 <<< 23) - 1;
    localparam longint TURN_MIN     = -TURN_MAX - 1;
    localparam longint TURN_SPAN    = 131070;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  angle;
        logic signed [SCALED_W-1:0] vel;
        logic signed [SCALED_W-1:0] tor;
        logic signed [7:0]          tmos;
        logic signed [7:0]          trot;
        logic [3:0]                 fault;
        logic signed [TURNS_W-1:0]  turns;
    } t_feedback;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_cmd = 1'b0;
    logic                       i_std_frame = 1'b0;
    logic [ID_W-1:0]            i_frame_id = '0;
    logic [PAYLOAD_W-1:0]       i_payload = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [ANGLE_W-1:0]  o_abs_angle;
    logic signed [SCALED_W-1:0] o_velocity;
    logic signed [SCALED_W-1:0] o_torque;
    logic signed [7:0]          o_drv_temp;
    logic signed [7:0]          o_rot_temp;
    logic [3:0]                 o_fault_state;
    logic signed [TURNS_W-1:0]  o_turns;

    t_feedback        pending_fb[$];
    t_cfg             cfg_model = '0;
    logic [POS_W-1:0] last_pos = POS_RESET;
    longint           turn_cnt = 0;
    longint           zero_ofs = 0;
    int               frames_kept = 0;
    int               mismatch_count = 0;
    int               stall_left = 0;
    bit               quiet = 1'b0;

    motor_feedback_frame_decoder uut (.*);

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // gain is Q.24, result Q.16 rounded half up, saturated to width bits
    function automatic logic signed [63:0] gain_scale(input longint count,
                                                      input logic signed [GAIN_W-1:0] gain,
                                                      input int bits);
        logic signed [95:0] prod;
        logic signed [95:0] rounded;
        logic signed [95:0] hi_lim;
        logic signed [95:0] lo_lim;
        prod    = count * gain;
        rounded = (prod + 96'sd128) >>> FRAC_DROP;
        hi_lim  = (96'sd1 <<< (bits - 1)) - 96'sd1;
        lo_lim  = -(96'sd1 <<< (bits - 1));
        if (rounded > hi_lim)
            rounded = hi_lim;
        else if (rounded < lo_lim)
            rounded = lo_lim;
        return rounded[63:0];
    endfunction

    task automatic zero_here();
        longint p;
        p = last_pos;
        turn_cnt = 0;
        zero_ofs = 2 * p - 65535;
    endtask

    task automatic track_frame(input logic cmd, input logic std, input logic [ID_W-1:0] id,
                               input logic [PAYLOAD_W-1:0] data);
        logic [POS_W-1:0]   pos;
        longint             c;
        longint             d;
        longint             vc;
        longint             tc;
        logic signed [63:0] scaled;
        t_feedback          fb;
        if (cmd) begin
            zero_here();
            return;
        end
        if (!std || id != cfg_model.host_id || data[59:56] != cfg_model.motor_id)
            return;
        pos = data[55:40];
        if (pos <= POS_LOW_MAX && last_pos >= POS_HIGH_MIN) begin
            if (turn_cnt < TURN_MAX)
                turn_cnt++;
        end else if (pos >= POS_HIGH_MIN && last_pos <= POS_LOW_MAX) begin
            if (turn_cnt > TURN_MIN)
                turn_cnt--;
        end
        last_pos = pos;
        if (frames_kept < FRAMES_MAX)
            frames_kept++;
        if (frames_kept == ZERO_FRAME && cfg_model.zero_en)
            zero_here();
        c = pos;
        c = 2 * c - 65535;
        d = turn_cnt * TURN_SPAN + c - zero_ofs;
        scaled = gain_scale(d, cfg_model.pos_gain, ANGLE_W);
        fb.angle = scaled[ANGLE_W-1:0];
        vc = data[39:28];
        vc = 2 * vc - 4095;
        scaled = gain_scale(vc, cfg_model.vel_gain, SCALED_W);
        fb.vel = scaled[SCALED_W-1:0];
        tc = data[27:16];
        tc = 2 * tc - 4095;
        scaled = gain_scale(tc, cfg_model.tor_gain, SCALED_W);
        fb.tor = scaled[SCALED_W-1:0];
        fb.tmos  = data[15:8];
        fb.trot  = data[7:0];
        fb.fault = data[63:60];
        fb.turns = turn_cnt[TURNS_W-1:0];
        pending_fb.push_back(fb);
    endtask

    always @(posedge i_clk) begin : check_out
        t_feedback want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fb.size() == 0) begin
                flag_mismatch("unexpected transaction", 64'(o_abs_angle), 64'd0);
            end else begin
                want = pending_fb.pop_front();
                if (o_abs_angle !== want.angle)
                    flag_mismatch("abs_angle", 64'(o_abs_angle), 64'(want.angle));
                if (o_velocity !== want.vel)
                    flag_mismatch("velocity", 64'(o_velocity), 64'(want.vel));
                if (o_torque !== want.tor)
                    flag_mismatch("torque", 64'(o_torque), 64'(want.tor));
                if (o_drv_temp !== want.tmos)
                    flag_mismatch("drv_temp", 64'(o_drv_temp), 64'(want.tmos));
                if (o_rot_temp !== want.trot)
                    flag_mismatch("rot_temp", 64'(o_rot_temp), 64'(want.trot));
                if (o_fault_state !== want.fault)
                    flag_mismatch("fault_state", 64'(o_fault_state), 64'(want.fault));
                if (o_turns !== want.turns)
                    flag_mismatch("turns", 64'(o_turns), 64'(want.turns));
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic cmd, input logic std, input logic [ID_W-1:0] id,
                             input logic [PAYLOAD_W-1:0] data);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_std_frame <= std;
        i_frame_id  <= id;
        i_payload   <= data;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        track_frame(cmd, std, id, data);
    endtask

    task automatic send_kept(input logic [3:0] fault, input logic [POS_W-1:0] pos,
                             input logic [RAW12_W-1:0] vel, input logic [RAW12_W-1:0] tor,
                             input logic [7:0] tmos, input logic [7:0] trot);
        send_item(1'b0, 1'b1, cfg_model.host_id,
                  {fault, cfg_model.motor_id, pos, vel, tor, tmos, trot});
    endtask

    task automatic send_random(input int keep_pct);
        logic [PAYLOAD_W-1:0] data;
        logic [ID_W-1:0]      id;
        logic                 std;
        logic                 cmd;
        data = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: data[55:40] = 16'($urandom_range(0, POS_LOW_MAX));
            1: data[55:40] = 16'($urandom_range(POS_HIGH_MIN, 16'hFFFF));
            2: data[55:40] = 16'($urandom_range(POS_LOW_MAX, POS_HIGH_MIN));
            default: data[55:40] = 16'($urandom);
        endcase
        data[59:56] = cfg_model.motor_id;
        id  = cfg_model.host_id;
        std = 1'b1;
        cmd = 1'b0;
        if ($urandom_range(0, 99) >= keep_pct) begin
            case ($urandom_range(0, 4))
                0: cmd = 1'b1;
                1: std = 1'b0;
                2: id = ID_W'($urandom);
                3: data[59:56] = 4'($urandom);
                default: begin
                    cmd = 1'($urandom);
                    std = 1'($urandom);
                    id  = ID_W'($urandom);
                end
            endcase
        end
        send_item(cmd, std, id, data);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_fb.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic configure(input t_cfg setting);
        write_reg(CFG_HOST_ID, CFG_DATA_W'(setting.host_id));
        write_reg(CFG_MOTOR_ID, CFG_DATA_W'(setting.motor_id));
        write_reg(CFG_POS_GAIN, setting.pos_gain);
        write_reg(CFG_VEL_GAIN, setting.vel_gain);
        write_reg(CFG_TOR_GAIN, setting.tor_gain);
        write_reg(CFG_ZERO_EN, CFG_DATA_W'(setting.zero_en));
        i_cfg_valid <= 1'b0;
        cfg_model = setting;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 5))
            0: g = '0;
            1: g = 32'h7FFF_FFFF;
            2: g = 32'h8000_0000;
            3, 4: begin
                g = $urandom_range(0, 32'h03FF_FFFF);
                if ($urandom_range(0, 1) == 1)
                    g = -g;
            end
            default: g = $urandom;
        endcase
        return g;
    endfunction

    // field extremes, rejects, zero command and wrap thresholds
    task automatic test_directed_decode();
        t_cfg setting;
        setting.host_id   = 11'h123;
        setting.motor_id  = 4'h5;
        setting.pos_gain  = 32'h0100_0000;
        setting.vel_gain  = 32'h7FFF_FFFF;
        setting.tor_gain  = 32'h8000_0000;
        setting.zero_en   = 1'b0;
        drain_block();
        configure(setting);
        send_kept(4'hF, 16'h0000, 12'h000, 12'h000, 8'h80, 8'h7F);
        send_kept(4'h0, 16'hFFFF, 12'hFFF, 12'hFFF, 8'h7F, 8'h80);
        send_kept(4'hA, 16'h0000, 12'h800, 12'h7FF, 8'h00, 8'hFF);
        send_item(1'b0, 1'b0, cfg_model.host_id, {4'h1, cfg_model.motor_id, 56'h12345678});
        send_item(1'b0, 1'b1, cfg_model.host_id ^ 11'h001, {4'h1, cfg_model.motor_id, 56'h0});
        send_item(1'b0, 1'b1, cfg_model.host_id, {4'h1, ~cfg_model.motor_id, 56'h0});
        send_kept(4'h5, 16'd50000, 12'h123, 12'hABC, 8'h11, 8'h22);
        send_item(1'b1, 1'b0, 11'h7FF, 64'hDEAD_BEEF_0123_4567);
        send_kept(4'h3, POS_LOW_MAX, 12'h001, 12'hFFE, 8'hFE, 8'h01);
        send_kept(4'h4, POS_HIGH_MIN, 12'h7FF, 12'h800, 8'h55, 8'hAA);
        send_kept(4'h6, POS_LOW_MAX + 16'd1, 12'h456, 12'h789, 8'hC3, 8'h3C);
        send_kept(4'h7, POS_HIGH_MIN - 16'd1, 12'hF0F, 12'h0F0, 8'h99, 8'h66);
        send_kept(4'h8, 16'h0000, 12'h555, 12'hAAA, 8'h01, 8'hFE);
    endtask

    // half-count products fall exactly on a rounding tie of either sign
    task automatic test_rounding_ties();
        t_cfg setting;
        setting.host_id   = '0;
        setting.motor_id  = 4'h0;
        setting.pos_gain  = 32'h8000_0000;
        setting.vel_gain  = 32'h0000_0080;
        setting.tor_gain  = 32'hFFFF_FF80;
        setting.zero_en   = 1'b0;
        drain_block();
        configure(setting);
        send_kept(4'h2, 16'h1234, 12'h800, 12'h7FF, 8'h10, 8'hF0);
        send_kept(4'hC, 16'h8000, 12'h7FF, 12'h800, 8'hF0, 8'h10);
        send_item(1'b1, 1'b1, '0, '0);
        send_kept(4'h9, 16'hFFFF, 12'h000, 12'hFFF, 8'h7F, 8'h7F);
        send_item(1'b0, 1'b0, '0, 64'h0);
    endtask

    task automatic test_frame_count_zero();
        t_cfg setting;
        setting.host_id   = ID_W'($urandom);
        setting.motor_id  = 4'($urandom);
        setting.pos_gain  = pick_gain();
        setting.vel_gain  = pick_gain();
        setting.tor_gain  = pick_gain();
        setting.zero_en   = 1'b1;
        drain_block();
        configure(setting);
        while (frames_kept < ZERO_FRAME + 5)
            send_random(90);
    endtask

    task automatic test_random_phases();
        t_cfg setting;
        for (int ph = 0; ph < 5; ph++) begin
            setting.host_id   = (ph == 0) ? 11'h000 : (ph == 1) ? 11'h7FF : 11'($urandom);
            setting.motor_id  = (ph == 0) ? 4'hF : (ph == 1) ? 4'h0 : 4'($urandom);
            setting.pos_gain  = pick_gain();
            setting.vel_gain  = pick_gain();
            setting.tor_gain  = pick_gain();
            setting.zero_en   = 1'($urandom);
            drain_block();
            configure(setting);
            if (ph == 4)
                quiet = 1'b1;
            repeat (135) send_random(85);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_decode();
        test_rounding_ties();
        test_frame_count_zero();
        test_random_phases();
        drain_block();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mfd_pkg.sv
rtl/core/mfd_track.sv
rtl/core/mfd_scale.sv
rtl/core/motor_feedback_frame_decoder.sv
verif/testbench.sv
